### rtl/tdss_pkg.sv
`timescale 1ns / 1ps
package tdss_pkg;

   localparam int VAL_W = 14;
   localparam int DIG_W = 4;
   localparam int NUM_STAGE_DIGITS = 3;
   localparam int RECIP_W = 13;
   localparam int RECIP_SHIFT = 16;
   localparam int PROD_W = VAL_W + RECIP_W;
   localparam int QUO_W = PROD_W - RECIP_SHIFT;

   // floor(x * 6554 / 2^16) equals floor(x / 10) for every x below 2^14.
   localparam logic [RECIP_W-1:0] RECIP_TEN = 13'd6554;
   localparam logic [VAL_W-1:0] TEN = 14'd10;
   localparam logic [7:0] SEG_DOT = 8'h80;

   typedef struct packed {
      logic [VAL_W-1:0] hundredths;
      logic [VAL_W-1:0] quo;
      logic [NUM_STAGE_DIGITS-1:0][DIG_W-1:0] digit;
   } pipe_type;

   function automatic logic [6:0] seg_code(input logic [DIG_W-1:0] d);
      logic [6:0] code;
      case (d)
         4'd0: code = 7'h3f;
         4'd1: code = 7'h06;
         4'd2: code = 7'h5b;
         4'd3: code = 7'h4f;
         4'd4: code = 7'h66;
         4'd5: code = 7'h6d;
         4'd6: code = 7'h7d;
         4'd7: code = 7'h07;
         4'd8: code = 7'h7f;
         4'd9: code = 7'h6f;
         default: code = 7'h00;
      endcase
      return code;
   endfunction

endpackage

### rtl/tdss_scale.sv
`timescale 1ns / 1ps
module tdss_scale
   import tdss_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   input  logic [7:0]     raw_low,
   input  logic [7:0]     raw_high,
   output logic           up_stall,
   output logic           out_valid,
   output pipe_type       out_data,
   input  logic           down_stall
);

   logic [15:0] raw;
   logic [15:0] prod;
   logic        valid_ff;
   logic        valid_in;
   pipe_type    data_ff;
   pipe_type    data_in;

   assign raw = {raw_high, raw_low};

   // raw * 25 as raw*16 + raw*8 + raw, wrapping at 16 bits.
   assign prod = (raw << 4) + (raw << 3) + raw;

   assign up_stall = valid_ff && down_stall;
   assign valid_in = in_valid;

   always_comb begin
      data_in = '0;
      data_in.hundredths = prod[15:2];
      data_in.quo = prod[15:2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!up_stall) begin
         valid_ff <= valid_in;
      end
      if (!up_stall) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data = data_ff;

endmodule

### rtl/tdss_digit.sv
`timescale 1ns / 1ps
module tdss_digit
   import tdss_pkg::*;
#(
   parameter int POS = 0
)
(
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   input  pipe_type  in_data,
   output logic      up_stall,
   output logic      out_valid,
   output pipe_type  out_data,
   input  logic      down_stall
);

   logic [PROD_W-1:0] prod;
   logic [VAL_W-1:0]  quo;
   logic [VAL_W-1:0]  rem;
   logic              valid_ff;
   pipe_type          data_ff;
   pipe_type          data_in;

   assign prod = {{RECIP_W{1'b0}}, in_data.quo} * {{VAL_W{1'b0}}, RECIP_TEN};
   assign quo = {{(VAL_W-QUO_W){1'b0}}, prod[PROD_W-1:RECIP_SHIFT]};
   assign rem = in_data.quo - ((quo << 3) + (quo << 1));

   always_comb begin
      data_in = in_data;
      data_in.quo = quo;
      data_in.digit[POS] = rem[DIG_W-1:0];
   end

   assign up_stall = valid_ff && down_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!up_stall) begin
         valid_ff <= in_valid;
      end
      if (!up_stall) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data = data_ff;

endmodule

### rtl/tdss_encode.sv
`timescale 1ns / 1ps
module tdss_encode
   import tdss_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  pipe_type          in_data,
   output logic              up_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [VAL_W-1:0]  rsp_hundredths,
   output logic [6:0]        rsp_seg_ones,
   output logic [6:0]        rsp_seg_tens,
   output logic [7:0]        rsp_seg_hundreds,
   output logic [6:0]        rsp_seg_thousands
);

   logic [VAL_W-1:0] thou_wide;
   logic [DIG_W-1:0] thou;
   logic             valid_ff;
   logic [VAL_W-1:0] hundredths_ff;
   logic [6:0]       ones_ff;
   logic [6:0]       tens_ff;
   logic [7:0]       hundreds_ff;
   logic [6:0]       thousands_ff;

   // The remaining quotient is below 17, so one subtraction gives the digit.
   assign thou_wide = (in_data.quo >= TEN) ? (in_data.quo - TEN) : in_data.quo;
   assign thou = thou_wide[DIG_W-1:0];

   assign up_stall = valid_ff && rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!up_stall) begin
         valid_ff <= in_valid;
      end
      if (!up_stall) begin
         hundredths_ff <= in_data.hundredths;
         ones_ff <= seg_code(in_data.digit[0]);
         tens_ff <= seg_code(in_data.digit[1]);
         hundreds_ff <= {1'b0, seg_code(in_data.digit[2])} | SEG_DOT;
         thousands_ff <= seg_code(thou);
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_hundredths = hundredths_ff;
   assign rsp_seg_ones = ones_ff;
   assign rsp_seg_tens = tens_ff;
   assign rsp_seg_hundreds = hundreds_ff;
   assign rsp_seg_thousands = thousands_ff;

endmodule

### rtl/temperature_to_seven_segment.sv
`timescale 1ns / 1ps
// Converts a raw temperature reading into hundredths of a degree and four
// seven-segment digit codes for a common-cathode display.
// Input channel: req_valid with req_raw_low and req_raw_high, one reading per
// transfer, held back while req_stall is high.
// Result channel: rsp_valid with rsp_hundredths and the four segment codes;
// the hundreds code always carries the decimal point in bit 7.
// The block is a five-stage pipeline: scale by 25, three divide-by-ten
// stages that each peel off one digit, and a segment encode stage that
// drives the result registers. One reading can be taken every cycle
// while req_stall is low.
// Each stage holds its item while the stage after it is full and stalled,
// so empty stages still fill up while the receiver stalls; req_stall rises
// only once the first stage is occupied and cannot move on.
// Reset clears all stage valid bits; no result is pending afterward.
module temperature_to_seven_segment
   import tdss_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [7:0]        req_raw_low,
   input  logic [7:0]        req_raw_high,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [VAL_W-1:0]  rsp_hundredths,
   output logic [6:0]        rsp_seg_ones,
   output logic [6:0]        rsp_seg_tens,
   output logic [7:0]        rsp_seg_hundreds,
   output logic [6:0]        rsp_seg_thousands
);

   logic [NUM_STAGE_DIGITS:0] valid;
   logic [NUM_STAGE_DIGITS:0] stall;
   logic                      enc_stall;
   pipe_type                  data [NUM_STAGE_DIGITS+1];

   tdss_scale u_scale (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .raw_low    (req_raw_low),
      .raw_high   (req_raw_high),
      .up_stall   (req_stall),
      .out_valid  (valid[0]),
      .out_data   (data[0]),
      .down_stall (stall[0])
   );

   for (genvar i = 0; i < NUM_STAGE_DIGITS; i++) begin : g_digit
      tdss_digit #(
         .POS (i)
      ) u_digit (
         .clock      (clock),
         .reset      (reset),
         .in_valid   (valid[i]),
         .in_data    (data[i]),
         .up_stall   (stall[i]),
         .out_valid  (valid[i+1]),
         .out_data   (data[i+1]),
         .down_stall (stall[i+1])
      );
   end

   assign stall[NUM_STAGE_DIGITS] = enc_stall;

   tdss_encode u_encode (
      .clock             (clock),
      .reset             (reset),
      .in_valid          (valid[NUM_STAGE_DIGITS]),
      .in_data           (data[NUM_STAGE_DIGITS]),
      .up_stall          (enc_stall),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_hundredths    (rsp_hundredths),
      .rsp_seg_ones      (rsp_seg_ones),
      .rsp_seg_tens      (rsp_seg_tens),
      .rsp_seg_hundreds  (rsp_seg_hundreds),
      .rsp_seg_thousands (rsp_seg_thousands)
   );

endmodule
